// ===== rtl/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared widths, codes and types of the adsr envelope generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

  // full-scale gain, a power of two so that the sample scaling is a shift
  localparam int GAIN_FULL  = 16384;
  localparam int REG_W      = 15;
  localparam int CNT_W      = 31;
  localparam int SAMPLE_W   = 16;
  localparam int KEY_W      = 2;
  localparam int PHASE_W    = 2;
  localparam int IDX_W      = 3;

  localparam int REG_MAX    = 2**REG_W - 1;
  localparam int GAIN_MAX   = (GAIN_FULL > REG_MAX) ? GAIN_FULL : REG_MAX;
  localparam int GAIN_W     = $clog2(GAIN_MAX + 1);
  localparam int SUM_W      = $clog2(GAIN_MAX + REG_MAX + 1);
  localparam int PROD_W     = CNT_W + REG_W;
  localparam int SCALE_SH   = $clog2(GAIN_FULL / 4);
  localparam int MUL_W      = GAIN_W - 1 + SAMPLE_W;

  localparam logic [GAIN_W-1:0] GAIN_FULL_G  = GAIN_W'(GAIN_FULL);
  localparam logic [GAIN_W-1:0] GAIN_FLOOR_G = GAIN_W'(4);

  // key event codes
  localparam logic [KEY_W-1:0] KEY_ON  = 2'd1;
  localparam logic [KEY_W-1:0] KEY_OFF = 2'd2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [IDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [IDX_W-1:0] REG_SUSTAIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_RELEASE = 3'd3;
  localparam logic [IDX_W-1:0] REG_FADE    = 3'd4;

  // register reset values
  localparam logic [REG_W-1:0] ATTACK_RST  = 15'd1024;
  localparam logic [REG_W-1:0] DECAY_RST   = 15'd8;
  localparam logic [REG_W-1:0] SUSTAIN_RST = 15'd4096;
  localparam logic [REG_W-1:0] RELEASE_RST = 15'd2;
  localparam logic [REG_W-1:0] FADE_RST    = 15'd0;

  typedef enum logic [PHASE_W-1:0] {
    PH_ATTACK  = 2'd0,
    PH_DECAY   = 2'd1,
    PH_RELEASE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [REG_W-1:0] attack_step;
    logic [REG_W-1:0] decay_step;
    logic [REG_W-1:0] sustain_gain;
    logic [REG_W-1:0] release_step;
    logic [REG_W-1:0] fade_step;
  } cfg_regs_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    phase_t            phase;
    logic              released;
    logic [CNT_W-1:0]  cnt;
  } env_state_t;

endpackage

// ===== rtl/adsr_in_if.sv =====
// ----------------------------------------------------------------------------
// adsr_in_if
// Tick channel: key event and waveform sample with valid/ready.
// ----------------------------------------------------------------------------
interface adsr_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [adsr_pkg::KEY_W-1:0]             key_event;
  logic signed [adsr_pkg::SAMPLE_W-1:0]   wave_sample;

  modport source (output valid, output key_event, output wave_sample, input ready);
  modport sink   (input valid, input key_event, input wave_sample, output ready);
endinterface

// ===== rtl/adsr_out_if.sv =====
// ----------------------------------------------------------------------------
// adsr_out_if
// Result channel: gain, phase and scaled sample with valid/ready.
// ----------------------------------------------------------------------------
interface adsr_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [adsr_pkg::REG_W-1:0]             envelope_gain;
  logic [adsr_pkg::PHASE_W-1:0]           env_phase;
  logic signed [adsr_pkg::SAMPLE_W-1:0]   scaled_sample;

  modport source (output valid, output envelope_gain, output env_phase,
                  output scaled_sample, input ready);
  modport sink   (input valid, input envelope_gain, input env_phase,
                  input scaled_sample, output ready);
endinterface

// ===== rtl/adsr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// adsr_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
interface adsr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [adsr_pkg::IDX_W-1:0]     index;
  logic [adsr_pkg::REG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/adsr_update.sv =====
// ----------------------------------------------------------------------------
// adsr_update
// One envelope step: key event, phase update, held counter and sample scaling.
// ----------------------------------------------------------------------------
module adsr_update (
  input  adsr_pkg::cfg_regs_t                  cfg,
  input  adsr_pkg::env_state_t                 cur,
  input  logic [adsr_pkg::PROD_W-1:0]          fade_prod,
  input  logic [adsr_pkg::KEY_W-1:0]           key_event,
  input  logic signed [adsr_pkg::SAMPLE_W-1:0] wave_sample,
  output adsr_pkg::env_state_t                 nxt,
  output logic signed [adsr_pkg::SAMPLE_W-1:0] scaled_sample
);
  import adsr_pkg::*;

  localparam logic signed [MUL_W-1:0] SAT_HI = MUL_W'(2**(SAMPLE_W-1) - 1);
  localparam logic signed [MUL_W-1:0] SAT_LO = -MUL_W'(2**(SAMPLE_W-1));
  localparam logic signed [MUL_W-1:0] RND    = MUL_W'(2**SCALE_SH - 1);
  localparam logic signed [MUL_W-1:0] NO_RND = '0;

  env_state_t              st;
  logic [SUM_W-1:0]        att_sum;
  logic [SUM_W-1:0]        dec_floor;
  logic [REG_W-1:0]        rel_step;
  logic [GAIN_W-2:0]       gain_q;
  logic signed [MUL_W-1:0] mul;
  logic signed [MUL_W-1:0] quot;

  assign att_sum   = SUM_W'(cur.gain) + SUM_W'(cfg.attack_step);
  assign dec_floor = SUM_W'(cfg.decay_step) + SUM_W'(cfg.sustain_gain);
  assign rel_step  = (cur.gain > GAIN_W'(cfg.sustain_gain)) ? cfg.decay_step
                                                            : cfg.release_step;

  always_comb begin
    // key event first
    st = cur;
    if (key_event == KEY_ON) begin
      st.released = 1'b0;
      st.cnt      = '0;
      st.phase    = PH_ATTACK;
    end else if (key_event == KEY_OFF) begin
      st.released = 1'b1;
    end

    nxt = st;
    unique case (st.phase)
      PH_ATTACK: begin
        if (st.released) begin
          nxt.phase = PH_RELEASE;
        end else if (att_sum > SUM_W'(GAIN_FULL_G)) begin
          nxt.gain  = GAIN_FULL_G;
          nxt.phase = PH_DECAY;
        end else begin
          nxt.gain = GAIN_W'(att_sum);
        end
      end
      PH_DECAY: begin
        if (st.released) begin
          nxt.phase = PH_RELEASE;
        end else if (SUM_W'(st.gain) < dec_floor) begin
          nxt.gain  = GAIN_W'(cfg.sustain_gain);
          nxt.phase = PH_RELEASE;
          nxt.cnt   = CNT_W'(1);
        end else begin
          nxt.gain = st.gain - GAIN_W'(cfg.decay_step);
        end
      end
      default: begin
        // sustain while held, release otherwise; fade product is cnt * fade
        if (!st.released) begin
          if (fade_prod > PROD_W'(cfg.sustain_gain)) begin
            nxt.gain     = GAIN_FLOOR_G;
            nxt.released = 1'b1;
          end else begin
            nxt.gain = GAIN_W'(cfg.sustain_gain - fade_prod[REG_W-1:0]);
          end
        end else if (st.gain != '0) begin
          if (st.gain < GAIN_W'(rel_step)) begin
            nxt.gain = '0;
          end else begin
            nxt.gain = st.gain - GAIN_W'(rel_step);
          end
        end
      end
    endcase

    // held counter, saturating
    if (!nxt.released && (nxt.cnt != '1)) begin
      nxt.cnt = nxt.cnt + CNT_W'(1);
    end
  end

  // sample scaled by (gain / 4) / (full / 4), rounded toward zero
  assign gain_q = nxt.gain[GAIN_W-1:2];
  assign mul    = $signed({1'b0, gain_q}) * wave_sample;
  assign quot   = (mul + (mul[MUL_W-1] ? RND : NO_RND)) >>> SCALE_SH;

  always_comb begin
    if (quot > SAT_HI) begin
      scaled_sample = SAMPLE_W'(SAT_HI);
    end else if (quot < SAT_LO) begin
      scaled_sample = SAMPLE_W'(SAT_LO);
    end else begin
      scaled_sample = quot[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== rtl/adsr_envelope_generator.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// ADSR envelope with sustain fade, applied to one waveform sample per tick.
// ----------------------------------------------------------------------------
//
//  channel  | dir | transaction                        | payload
//  ---------+-----+------------------------------------+---------------------------
//  in_ch    | in  | one audio tick                     | key_event, wave_sample
//  out_ch   | out | one result per tick                | envelope_gain, env_phase,
//           |     |                                    | scaled_sample
//  cfg_ch   | in  | one register write (always ready)  | index, data
//
//  one tick per clock unless a config write or a stalled result holds it: accepted
//  ticks land in an input register, the envelope update and the scaling multiply run
//  between that and the result register, which drives result valid
//  a config write stalls the ticks while the registered fade product
//  (held count times fade step) is refreshed from the new setting
//  the input register takes one more tick while a result is stalled, then
//  in_ch.ready drops until out_ch moves
//  synchronous active-low reset: gain 0, attack phase, key released
//
module adsr_envelope_generator (
  input  logic       clk,
  input  logic       rst_n,
  adsr_in_if.sink    in_ch,
  adsr_out_if.source out_ch,
  adsr_cfg_if.sink   cfg_ch
);
  import adsr_pkg::*;

  // configuration and envelope state
  cfg_regs_t          cfg_r;
  env_state_t         st_r;
  env_state_t         st_nxt;

  // fade product for the current held count, kept one step ahead
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_nxt;
  logic [CNT_W-1:0]   prod_cnt;
  logic               stale_r;

  // input register
  logic                       in_valid_r;
  logic [KEY_W-1:0]           in_key_r;
  logic signed [SAMPLE_W-1:0] in_sample_r;

  // result register
  logic                       out_valid_r;
  logic [REG_W-1:0]           out_gain_r;
  logic [PHASE_W-1:0]         out_phase_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic signed [SAMPLE_W-1:0] scaled_nxt;

  logic advance;
  logic in_take;
  logic cfg_take;

  // a tick moves on when the result slot is free and the fade product is current
  assign advance  = in_valid_r && !stale_r && (!out_valid_r || out_ch.ready);
  assign in_take  = in_ch.valid && in_ch.ready;
  assign cfg_take = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.envelope_gain = out_gain_r;
  assign out_ch.env_phase     = out_phase_r;
  assign out_ch.scaled_sample = out_sample_r;

  adsr_update u_update (
    .cfg           (cfg_r),
    .cur           (st_r),
    .fade_prod     (prod_r),
    .key_event     (in_key_r),
    .wave_sample   (in_sample_r),
    .nxt           (st_nxt),
    .scaled_sample (scaled_nxt)
  );

  // product for the next tick, or a refresh after a config write
  assign prod_cnt = stale_r ? st_r.cnt : st_nxt.cnt;
  assign prod_nxt = PROD_W'(prod_cnt) * PROD_W'(cfg_r.fade_step);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_step  <= ATTACK_RST;
      cfg_r.decay_step   <= DECAY_RST;
      cfg_r.sustain_gain <= SUSTAIN_RST;
      cfg_r.release_step <= RELEASE_RST;
      cfg_r.fade_step    <= FADE_RST;
      st_r.gain          <= '0;
      st_r.phase         <= PH_ATTACK;
      st_r.released      <= 1'b1;
      st_r.cnt           <= '0;
      prod_r             <= '0;
      stale_r            <= 1'b0;
      in_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      if (cfg_take) begin
        unique case (cfg_ch.index)
          REG_ATTACK:  cfg_r.attack_step  <= cfg_ch.data;
          REG_DECAY:   cfg_r.decay_step   <= cfg_ch.data;
          REG_SUSTAIN: cfg_r.sustain_gain <= cfg_ch.data;
          REG_RELEASE: cfg_r.release_step <= cfg_ch.data;
          REG_FADE:    cfg_r.fade_step    <= cfg_ch.data;
          default: ;
        endcase
      end

      if (stale_r || advance) begin
        prod_r <= prod_nxt;
      end
      stale_r <= cfg_take;

      if (advance) begin
        st_r <= st_nxt;
      end

      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_key_r    <= in_ch.key_event;
      in_sample_r <= in_ch.wave_sample;
    end
    if (advance) begin
      out_gain_r   <= st_nxt.gain[REG_W-1:0];
      out_phase_r  <= st_nxt.phase;
      out_sample_r <= scaled_nxt;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the adsr envelope generator: a queue-fed driver and
// a clocked monitor, with an in-bench envelope predictor that checks every
// result against the tick that caused it, under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import adsr_pkg::*;

  // key codes the package leaves unnamed
  localparam logic [KEY_W-1:0] KEY_NONE  = 2'd0;
  localparam logic [KEY_W-1:0] KEY_SPARE = 2'd3;

  localparam int              SETTING_MAX    = 16384;  // largest setting the bench writes
  localparam int              PHASES         = 24;
  localparam int              TICKS_PER_PHASE = 56;
  localparam int              SETTLE_CYCLES  = 4;      // settle margin after the queues empty
  localparam int              LONG_STALL     = 80;     // receiver hold-off under pressure
  localparam longint          HELD_TOP       = 64'sd2147483647;
  localparam longint          RUN_LIMIT_NS   = 2_000_000;

  typedef struct packed {
    logic [KEY_W-1:0]           key;
    logic signed [SAMPLE_W-1:0] sample;
  } tick_t;

  typedef struct packed {
    logic [REG_W-1:0]           gain;
    phase_t                     phase;
    logic signed [SAMPLE_W-1:0] sample;
  } env_result_t;

  logic clk;
  logic rst_n;

  adsr_in_if  in_ch ();
  adsr_out_if out_ch ();
  adsr_cfg_if cfg_ch ();

  adsr_envelope_generator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // ticks waiting to be offered, and envelope results still owed by the block
  tick_t       tick_queue[$];
  env_result_t envelope_expect_q[$];

  int  queued_ticks   = 0;
  int  mismatch_count = 0;
  int  send_idle_pct  = 0;
  int  recv_idle_pct  = 0;
  bit  tick_taken     = 1'b0;
  bit  stall_trigger  = 1'b0;

  // predictor copy of the register file, reset values as in the block
  logic [REG_W-1:0] attack_q  = ATTACK_RST;
  logic [REG_W-1:0] decay_q   = DECAY_RST;
  logic [REG_W-1:0] sustain_q = SUSTAIN_RST;
  logic [REG_W-1:0] release_q = RELEASE_RST;
  logic [REG_W-1:0] fade_q    = FADE_RST;

  // predictor envelope state; held count of -1 means the key is up
  longint env_gain  = 0;
  phase_t env_phase = PH_ATTACK;
  longint held_cnt  = -1;
  longint fade_loss = 0;

  // clock, 4 ns period
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one audio tick of the envelope: key event first, then the phase step,
  // then the held counter, then the sample scaling
  function automatic env_result_t advance_envelope(input logic [KEY_W-1:0] key,
                                                   input logic signed [SAMPLE_W-1:0] smp);
    env_result_t res;
    longint      atk;
    longint      dcy;
    longint      sus;
    longint      rel;
    longint      fad;
    longint      lvl;
    longint      scaled;
    atk = longint'(attack_q);
    dcy = longint'(decay_q);
    sus = longint'(sustain_q);
    rel = longint'(release_q);
    fad = longint'(fade_q);

    // the spare key code counts as no event
    if (key == KEY_ON) begin
      held_cnt  = 0;
      env_phase = PH_ATTACK;
    end else if (key == KEY_OFF) begin
      held_cnt = -1;
    end

    case (env_phase)
      PH_ATTACK: begin
        // key up during attack: straight to release, gain untouched this tick
        if (held_cnt < 0) begin
          env_phase = PH_RELEASE;
        end else begin
          env_gain = env_gain + atk;
          if (env_gain > longint'(GAIN_FULL)) begin
            env_gain  = longint'(GAIN_FULL);
            env_phase = PH_DECAY;
          end
        end
      end
      PH_DECAY: begin
        if (held_cnt < 0) begin
          env_phase = PH_RELEASE;
        end else begin
          env_gain = env_gain - dcy;
          if (env_gain < sus) begin
            env_gain  = sus;
            env_phase = PH_RELEASE;
            held_cnt  = 1;
          end
        end
      end
      default: begin
        if (held_cnt >= 0) begin
          // sustain, fading with the held time
          fade_loss = held_cnt * fad;
          lvl       = sus - fade_loss;
          if (lvl < 0) begin
            env_gain = 4;
            held_cnt = -1;
          end else begin
            env_gain = lvl;
          end
        end else if (env_gain > 0) begin
          // release: decay slope above sustain, release slope at or below it
          if (env_gain > sus) env_gain = env_gain - dcy;
          else                env_gain = env_gain - rel;
          if (env_gain < 0) env_gain = 0;
        end
      end
    endcase

    if (held_cnt >= 0 && held_cnt < HELD_TOP) held_cnt = held_cnt + 1;

    scaled = ((env_gain >>> 2) * longint'(smp)) / longint'(GAIN_FULL / 4);
    if (scaled > 32767)       scaled = 32767;
    else if (scaled < -32768) scaled = -32768;

    res.gain   = env_gain[REG_W-1:0];
    res.phase  = env_phase;
    res.sample = scaled[SAMPLE_W-1:0];
    return res;
  endfunction

  // mostly full-range samples, with the two extremes now and then
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // register value: zero or SETTING_MAX, short slopes, or any value up to SETTING_MAX
  function automatic logic [REG_W-1:0] rand_setting();
    case ($urandom_range(5))
      0:       return '0;
      1:       return REG_W'(SETTING_MAX);
      2:       return REG_W'($urandom_range(1, 64));
      3:       return REG_W'($urandom_range(SETTING_MAX));
      default: return REG_W'($urandom_range(256, 8192));
    endcase
  endfunction

  task automatic queue_tick(input logic [KEY_W-1:0] key, input logic signed [SAMPLE_W-1:0] smp);
    tick_t t;
    t.key    = key;
    t.sample = smp;
    tick_queue.push_back(t);
    queued_ticks++;
  endtask

  // one register write; valid stays up for a following write
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      REG_ATTACK:  attack_q  = value;
      REG_DECAY:   decay_q   = value;
      REG_SUSTAIN: sustain_q = value;
      REG_RELEASE: release_q = value;
      REG_FADE:    fade_q    = value;
      default: ;
    endcase
  endtask

  // full register set, written only while the block is idle
  task automatic apply_setting(input logic [REG_W-1:0] atk, input logic [REG_W-1:0] dcy,
                               input logic [REG_W-1:0] sus, input logic [REG_W-1:0] rel,
                               input logic [REG_W-1:0] fad);
    write_reg(REG_ATTACK, atk);
    write_reg(REG_DECAY, dcy);
    write_reg(REG_SUSTAIN, sus);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_FADE, fad);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every tick has been taken and every result checked
  task automatic drain();
    do @(posedge clk); while (tick_queue.size() != 0 || envelope_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // tick driver: holds a transaction until taken, otherwise offers the next
  // queued tick unless it chooses to idle this cycle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !tick_taken) begin
      // offer still pending, keep it steady
    end else if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_ch.valid       <= 1'b1;
      in_ch.key_event   <= tick_queue[0].key;
      in_ch.wave_sample <= tick_queue[0].sample;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // result ready: random back-pressure, plus a long hold-off counted here
  // whenever the stimulus flips the trigger
  always @(negedge clk) begin : result_ready
    bit stall_seen;
    int stall_left;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_seen    = stall_trigger;
      stall_left    = 0;
    end else begin
      if (stall_seen != stall_trigger) begin
        stall_seen = stall_trigger;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // monitor: predicts on every accepted tick, checks every accepted result
  // against the oldest prediction
  always @(posedge clk) begin : tick_monitor
    env_result_t want;
    tick_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        envelope_expect_q.push_back(advance_envelope(in_ch.key_event, in_ch.wave_sample));
        void'(tick_queue.pop_front());
      end
      if (out_ch.valid && out_ch.ready) begin
        if (envelope_expect_q.size() == 0) begin
          $error("result transaction with nothing expected: gain %0d phase %0d sample %0d",
                 out_ch.envelope_gain, out_ch.env_phase, out_ch.scaled_sample);
          mismatch_count++;
        end else begin
          want = envelope_expect_q.pop_front();
          if (out_ch.envelope_gain !== want.gain) begin
            $error("envelope_gain: expected %0d, got %0d", want.gain, out_ch.envelope_gain);
            mismatch_count++;
          end
          if (out_ch.env_phase !== want.phase) begin
            $error("env_phase: expected %0d, got %0d", want.phase, out_ch.env_phase);
            mismatch_count++;
          end
          if (out_ch.scaled_sample !== want.sample) begin
            $error("scaled_sample: expected %0d, got %0d", want.sample, out_ch.scaled_sample);
            mismatch_count++;
          end
        end
      end
    end
  end

  // stimulus: reset, directed envelope walk, then random phases
  initial begin : stimulus
    int               p;
    int               run;
    int               target;
    logic [REG_W-1:0] atk;
    logic [REG_W-1:0] dcy;
    logic [REG_W-1:0] sus;
    logic [REG_W-1:0] rel;
    logic [REG_W-1:0] fad;

    // every block input known from time zero
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.key_event   = KEY_NONE;
    in_ch.wave_sample = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_ATTACK;
    cfg_ch.data       = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 25;
    recv_idle_pct = 79;

    // reset settings: idle tick, attack, key up during attack, slow release
    queue_tick(KEY_NONE, 16'sh7FFF);
    queue_tick(KEY_ON, 16'sh8000);
    queue_tick(KEY_NONE, 16'sh7FFF);
    queue_tick(KEY_OFF, -16'sd1);
    queue_tick(KEY_NONE, 16'sd1);
    drain();

    // steep slopes: attack overshoot, decay to sustain, steady sustain,
    // release clamped at zero, key up in attack and in decay, spare key code
    apply_setting(15'd8192, 15'd4096, 15'd8192, REG_W'(SETTING_MAX), 15'd0);
    queue_tick(KEY_ON, 16'sh7FFF);
    queue_tick(KEY_NONE, 16'sh8000);
    queue_tick(KEY_NONE, 16'sh7FFF);
    queue_tick(KEY_NONE, 16'sh8000);
    queue_tick(KEY_NONE, -16'sd1);
    queue_tick(KEY_NONE, 16'sd0);
    queue_tick(KEY_OFF, 16'sh7FFF);
    queue_tick(KEY_ON, 16'sh8000);
    queue_tick(KEY_SPARE, 16'sh5555);
    queue_tick(KEY_OFF, -16'sh5556);
    queue_tick(KEY_NONE, 16'sh7FFF);
    queue_tick(KEY_ON, 16'sh8000);
    queue_tick(KEY_OFF, 16'sh7FFF);
    drain();

    // sustain fade below zero: gain drops to the floor and the key lets go
    apply_setting(REG_W'(SETTING_MAX), REG_W'(SETTING_MAX), 15'd8192, 15'd1,
                  REG_W'(SETTING_MAX));
    queue_tick(KEY_ON, 16'sh7FFF);
    queue_tick(KEY_NONE, 16'sh8000);
    queue_tick(KEY_NONE, 16'sh7FFF);
    queue_tick(KEY_NONE, 16'sh8000);
    drain();

    for (p = 0; p < PHASES; p++) begin
      // idling: sender light / receiver heavy, then swapped, then none
      if (p < PHASES / 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 79;
      end else if (p < 2 * PHASES / 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // first all zero, all SETTING_MAX and the reset set, then random settings
      case (p)
        0: begin
          atk = '0; dcy = '0; sus = '0; rel = '0; fad = '0;
        end
        1: begin
          atk = REG_W'(SETTING_MAX); dcy = REG_W'(SETTING_MAX); sus = REG_W'(SETTING_MAX);
          rel = REG_W'(SETTING_MAX); fad = REG_W'(SETTING_MAX);
        end
        2: begin
          atk = ATTACK_RST; dcy = DECAY_RST; sus = SUSTAIN_RST;
          rel = RELEASE_RST; fad = FADE_RST;
        end
        default: begin
          atk = rand_setting(); dcy = rand_setting(); sus = rand_setting();
          rel = rand_setting(); fad = rand_setting();
        end
      endcase
      apply_setting(atk, dcy, sus, rel, fad);

      // mostly whole notes (press, hold, let go, ring out), some key noise
      target = queued_ticks + TICKS_PER_PHASE;
      while (queued_ticks < target) begin
        if ($urandom_range(9) != 0) begin
          queue_tick(KEY_ON, rand_sample());
          run = $urandom_range(1, 40);
          repeat (run) queue_tick(KEY_NONE, rand_sample());
          queue_tick(KEY_OFF, rand_sample());
          run = $urandom_range(0, 20);
          repeat (run) queue_tick(KEY_NONE, rand_sample());
        end else begin
          run = $urandom_range(1, 6);
          repeat (run) queue_tick(KEY_W'($urandom_range(3)), rand_sample());
        end
      end

      // back-pressure: receiver holds off while the sender keeps offering
      if (p == 2 * PHASES / 3) stall_trigger = ~stall_trigger;

      drain();
    end

    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[adsr_envelope_generator] OK");
    end else begin
      $display("[adsr_envelope_generator] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("[adsr_envelope_generator] ERROR");
    $finish;
  end

endmodule
